/* src/interleave_grid_overlay_assert.svh */
// Assertion macros used by the grid overlay checker.
`ifndef INTERLEAVE_GRID_OVERLAY_ASSERT_SVH
`define INTERLEAVE_GRID_OVERLAY_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define IGO_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("grid overlay check failed");

// Check that a condition implies another in the next cycle.
`define IGO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("grid overlay check failed");

`endif

/* src/igo_pkg.sv */
// Shared constants, types and arithmetic helpers of the grid overlay.
package igo_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int MAX_GAP   = 64;
  localparam int FRAC_BITS = 16;

  localparam int PIX_W  = 24;
  localparam int DIM_W  = 12;
  localparam int GAP_W  = 7;
  localparam int DUR_W  = 7;
  localparam int COL_W  = $clog2(MAX_DIM);
  localparam int SM_W   = GAP_W + FRAC_BITS;
  localparam int SUM_W  = SM_W + 10;
  localparam int CNT_W  = $clog2(DIM_W + 1);
  localparam int IDX_W  = 3;

  localparam int SMOOTH_DEN   = 512;
  localparam int SMOOTH_BASE  = 448;
  localparam int SMOOTH_SHIFT = $clog2(SMOOTH_DEN);
  localparam int DUR_MAX      = SMOOTH_DEN - SMOOTH_BASE;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAP_X      = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAP_Y      = 3'd2;
  localparam logic [IDX_W-1:0] REG_COLOR      = 3'd3;
  localparam logic [IDX_W-1:0] REG_BEAT_EN    = 3'd4;
  localparam logic [IDX_W-1:0] REG_BEAT_GAP_X = 3'd5;
  localparam logic [IDX_W-1:0] REG_BEAT_GAP_Y = 3'd6;
  localparam logic [IDX_W-1:0] REG_DURATION   = 3'd7;

  // Blend modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_REPLACE = 2'd1;
  localparam logic [1:0] MODE_ADD     = 2'd2;
  localparam logic [1:0] MODE_AVG     = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step_in;     // process the pixel on the input port
    logic step_hold;   // process the held first pixel of a frame
    logic latch;       // capture a frame-start item
    logic smooth;      // update the smoothed cell sizes
    logic div_start;   // take cell sizes, launch the remainder units
    logic frame_init;  // load the frame pattern state
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic start_go;    // input item opens a painted frame
    logic div_done;    // remainder units idle
  } dp_status_t;

  function automatic logic [GAP_W-1:0] clamp_gap(logic [GAP_W-1:0] g);
    return (g > GAP_W'(MAX_GAP)) ? GAP_W'(MAX_GAP) : g;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // Move a size a step toward its target, rounding toward the target
  function automatic logic [SM_W-1:0] smooth_step(logic [SM_W-1:0] cur,
                                                  logic [GAP_W-1:0] gap,
                                                  logic [DUR_W-1:0] dur);
    logic [DUR_W-1:0] d;
    logic [9:0]       s;
    logic [DUR_W-1:0] rest;
    logic [SM_W-1:0]  tgt;
    logic [SUM_W-1:0] prod_a;
    logic [13:0]      prod_b;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] res;
    d      = (dur > DUR_W'(DUR_MAX)) ? DUR_W'(DUR_MAX) : dur;
    s      = 10'(d) + 10'(SMOOTH_BASE);
    rest   = DUR_W'(DUR_MAX) - d;
    tgt    = SM_W'(gap) << FRAC_BITS;
    prod_a = SUM_W'(cur) * SUM_W'(s);
    prod_b = 14'(gap) * 14'(rest);
    sum    = prod_a + (SUM_W'(prod_b) << FRAC_BITS);
    if (cur >= tgt) res = sum >> SMOOTH_SHIFT;
    else res = (sum + SUM_W'(SMOOTH_DEN - 1)) >> SMOOTH_SHIFT;
    return res[SM_W-1:0];
  endfunction

  // Per-channel saturating add
  function automatic logic [PIX_W-1:0] add_sat(logic [PIX_W-1:0] a,
                                               logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    logic [8:0]       v;
    r = '0;
    for (int ch = 0; ch < 3; ch++) begin
      v = {1'b0, a[ch*8 +: 8]} + {1'b0, b[ch*8 +: 8]};
      r[ch*8 +: 8] = v[8] ? 8'hff : v[7:0];
    end
    return r;
  endfunction

  // Per-channel average with truncation of each operand
  function automatic logic [PIX_W-1:0] avg_pix(logic [PIX_W-1:0] a,
                                               logic [PIX_W-1:0] b);
    return ((a >> 1) & 24'h7f7f7f) + ((b >> 1) & 24'h7f7f7f);
  endfunction

endpackage

/* src/interleave_grid_overlay.sv */
// Interleaved grid overlay: paints a grid of cells over a raster pixel stream.
// Timing: a pixel inside a frame, and the first pixel of a skipped frame or of a
// frame while the mode is off, goes straight to the output register, so such
// pixels stream at one per clock while the output is not stalled. The first
// pixel of a painted frame stalls the input while it is captured, the smoothed
// cell sizes are updated, the centering remainders are launched, the bit-serial
// remainder units run (one bit of the 12-bit frame size per cycle), the frame
// pattern state is loaded and the result is emitted. The output is registered;
// while a finished pixel waits on out_stall_i, the input is stalled.
// Configuration is always ready and is meant to be written between items.
module interleave_grid_overlay import igo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PIX_W-1:0] pixel_in_i,
  input  logic             frame_first_i,
  input  logic             beat_flag_i,
  input  logic             skip_frame_i,
  input  logic [DIM_W-1:0] frame_width_i,
  input  logic [DIM_W-1:0] frame_height_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  igo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  igo_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_in_i     (pixel_in_i),
    .frame_first_i  (frame_first_i),
    .beat_flag_i    (beat_flag_i),
    .skip_frame_i   (skip_frame_i),
    .frame_width_i  (frame_width_i),
    .frame_height_i (frame_height_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .pixel_out_o    (pixel_out_o)
  );

endmodule

/* src/igo_rem.sv */
// Iterative remainder unit: one dividend bit per cycle.
module igo_rem import igo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIM_W-1:0] dividend_i,
  input  logic [GAP_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [GAP_W-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W-1:0] num_q, num_d;
  logic [GAP_W-1:0] rem_q, rem_d;
  logic [GAP_W-1:0] div_q, div_d;
  logic [GAP_W:0]   trial;
  logic [GAP_W:0]   trial_sub;

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    trial     = {rem_q, num_q[DIM_W-1]};
    trial_sub = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    num_d     = num_q;
    rem_d     = rem_q;
    div_d     = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = trial_sub[GAP_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIM_W - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // A zero divisor gives a zero remainder
  assign busy_o = busy_q;
  assign rem_o  = (div_q == '0) ? '0 : rem_q;

endmodule

/* src/igo_dp.sv */
// Datapath: registers, size smoothing, grid pattern and blend.
module igo_dp import igo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0] pixel_in_i,
  input  logic             frame_first_i,
  input  logic             beat_flag_i,
  input  logic             skip_frame_i,
  input  logic [DIM_W-1:0] frame_width_i,
  input  logic [DIM_W-1:0] frame_height_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  output logic [PIX_W-1:0] pixel_out_o
);

  // Configuration
  logic [1:0]       mode_q;
  logic [GAP_W-1:0] gap_x_q, gap_y_q, beat_gx_q, beat_gy_q;
  logic [PIX_W-1:0] color_q;
  logic             beat_en_q;
  logic [DUR_W-1:0] dur_q;
  logic [GAP_W-1:0] cfg_gap;

  // Frame and pattern state
  logic [SM_W-1:0]  sw_q, sh_q, sw_new, sh_new;
  logic [GAP_W-1:0] cw_q, ch_q, cso_q, rp_q, cph_q;
  logic             rbo_q, cbo_q, pt_q;
  logic [COL_W-1:0] ci_q;
  logic [DIM_W-1:0] rw_q;

  // Held first pixel of a frame
  logic [PIX_W-1:0] pix_hold_q;
  logic             beat_hold_q;
  logic [DIM_W-1:0] w_hold_q, h_hold_q;

  logic [PIX_W-1:0] pixel_out_q;

  logic             busy_w, busy_h;
  logic [GAP_W-1:0] rem_w, rem_h;

  logic             step;
  logic             pt_eff;
  logic [PIX_W-1:0] pix_sel;
  logic             col0;
  logic [GAP_W:0]   rp_inc;
  logic [GAP_W-1:0] rp_n, cph_cur, cph_n;
  logic [GAP_W:0]   cph_inc;
  logic             rbo_n, cbo_cur, cbo_n, paint;
  logic [DIM_W-1:0] ci_inc;
  logic [COL_W-1:0] ci_n;
  logic [PIX_W-1:0] blend;

  assign cfg_gap = clamp_gap(cfg_data_i[GAP_W-1:0]);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_REPLACE;
      gap_x_q   <= GAP_W'(1);
      gap_y_q   <= GAP_W'(1);
      color_q   <= '0;
      beat_en_q <= 1'b0;
      beat_gx_q <= GAP_W'(1);
      beat_gy_q <= GAP_W'(1);
      dur_q     <= DUR_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:       mode_q    <= cfg_data_i[1:0];
        REG_GAP_X:      gap_x_q   <= cfg_data_i[GAP_W-1:0];
        REG_GAP_Y:      gap_y_q   <= cfg_data_i[GAP_W-1:0];
        REG_COLOR:      color_q   <= cfg_data_i;
        REG_BEAT_EN:    beat_en_q <= cfg_data_i[0];
        REG_BEAT_GAP_X: beat_gx_q <= cfg_data_i[GAP_W-1:0];
        REG_BEAT_GAP_Y: beat_gy_q <= cfg_data_i[GAP_W-1:0];
        REG_DURATION:   dur_q     <= cfg_data_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Smoothed sizes, snapped on a beat when beat snapping is enabled
  always_comb begin
    sw_new = smooth_step(sw_q, clamp_gap(gap_x_q), dur_q);
    sh_new = smooth_step(sh_q, clamp_gap(gap_y_q), dur_q);
    if (beat_hold_q && beat_en_q) begin
      sw_new = SM_W'(clamp_gap(beat_gx_q)) << FRAC_BITS;
      sh_new = SM_W'(clamp_gap(beat_gy_q)) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= SM_W'(1) << FRAC_BITS;
      sh_q <= SM_W'(1) << FRAC_BITS;
    end else if (cmd_i.smooth) begin
      sw_q <= sw_new;
      sh_q <= sh_new;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_GAP_X) sw_q <= SM_W'(cfg_gap) << FRAC_BITS;
      if (cfg_index_i == REG_GAP_Y) sh_q <= SM_W'(cfg_gap) << FRAC_BITS;
    end
  end

  // Hold the frame-start item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      pix_hold_q  <= pixel_in_i;
      beat_hold_q <= beat_flag_i;
      w_hold_q    <= clamp_dim(frame_width_i);
      h_hold_q    <= clamp_dim(frame_height_i);
    end
  end

  // Centering remainders of the frame size by the cell size
  igo_rem u_rem_w (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (w_hold_q),
    .divisor_i  (sw_q[SM_W-1:FRAC_BITS]),
    .busy_o     (busy_w),
    .rem_o      (rem_w)
  );

  igo_rem u_rem_h (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (h_hold_q),
    .divisor_i  (sh_q[SM_W-1:FRAC_BITS]),
    .busy_o     (busy_h),
    .rem_o      (rem_h)
  );

  // Pattern step for one pixel
  always_comb begin
    step    = cmd_i.step_in || cmd_i.step_hold;
    pt_eff  = (cmd_i.step_in && frame_first_i) || pt_q;
    pix_sel = cmd_i.step_hold ? pix_hold_q : pixel_in_i;
    col0    = (ci_q == '0);

    rp_n    = rp_q;
    rbo_n   = rbo_q;
    rp_inc  = {1'b0, rp_q} + (GAP_W+1)'(1);
    if (col0 && ch_q != '0) begin
      if (rp_inc >= {1'b0, ch_q}) begin
        rbo_n = ~rbo_q;
        rp_n  = '0;
      end else begin
        rp_n  = rp_inc[GAP_W-1:0];
      end
    end

    cbo_cur = col0 ? 1'b0 : cbo_q;
    cph_cur = col0 ? cso_q : cph_q;
    paint   = !rbo_n || (cw_q != '0 && !cbo_cur);

    cph_n   = cph_cur;
    cbo_n   = cbo_cur;
    cph_inc = {1'b0, cph_cur} + (GAP_W+1)'(1);
    if (cw_q != '0) begin
      if (cph_inc >= {1'b0, cw_q}) begin
        cph_n = '0;
        cbo_n = ~cbo_cur;
      end else begin
        cph_n = cph_inc[GAP_W-1:0];
      end
    end

    ci_inc = DIM_W'(ci_q) + DIM_W'(1);
    ci_n   = (ci_inc >= rw_q) ? '0 : ci_inc[COL_W-1:0];

    blend = pix_sel;
    if (paint && !pt_eff) begin
      case (mode_q)
        MODE_REPLACE: blend = color_q;
        MODE_ADD:     blend = add_sat(pix_sel, color_q);
        MODE_AVG:     blend = avg_pix(pix_sel, color_q);
        default:      blend = pix_sel;
      endcase
    end
  end

  // Pattern state: frame load and per-pixel advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q  <= '0;
      ch_q  <= '0;
      cso_q <= '0;
      rp_q  <= '0;
      rbo_q <= 1'b0;
      cph_q <= '0;
      cbo_q <= 1'b0;
      ci_q  <= '0;
      rw_q  <= DIM_W'(1);
      pt_q  <= 1'b1;
    end else begin
      if (cmd_i.div_start) begin
        cw_q <= sw_q[SM_W-1:FRAC_BITS];
        ch_q <= sh_q[SM_W-1:FRAC_BITS];
      end
      if (cmd_i.frame_init) begin
        cso_q <= rem_w >> 1;
        rp_q  <= rem_h >> 1;
        rbo_q <= (ch_q == '0);
        ci_q  <= '0;
        rw_q  <= w_hold_q;
        pt_q  <= 1'b0;
      end else if (step) begin
        if (cmd_i.step_in && frame_first_i) begin
          pt_q <= 1'b1;
        end else if (!pt_q) begin
          rp_q  <= rp_n;
          rbo_q <= rbo_n;
          cph_q <= cph_n;
          cbo_q <= cbo_n;
          ci_q  <= ci_n;
        end
      end
    end
  end

  // Output pixel register
  always_ff @(posedge clk_i) begin
    if (step) pixel_out_q <= blend;
  end

  assign pixel_out_o       = pixel_out_q;
  assign status_o.start_go = frame_first_i && !skip_frame_i && (mode_q != MODE_OFF);
  assign status_o.div_done = !busy_w && !busy_h;

endmodule

/* src/igo_ctrl.sv */
// Controller: handshakes and the frame-start sequence.
module igo_ctrl import igo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SMOOTH = 3'd1;
  localparam logic [2:0] S_DIVS   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Sequence the frame start; plain pixels go straight to the output
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (status_i.start_go) begin
            cmd_o.latch = 1'b1;
            state_d     = S_SMOOTH;
          end else begin
            cmd_o.step_in = 1'b1;
          end
        end
      end
      S_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.frame_init = 1'b1;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.step_hold = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Load on a new result, drop when the output transfer completes
  always_comb begin
    if (cmd_o.step_in || cmd_o.step_hold) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/igo_checker.sv */
// Port-level checker for the grid overlay, bound to the top level.
`include "interleave_grid_overlay_assert.svh"

module igo_checker import igo_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [PIX_W-1:0] pixel_in_i,
  input logic             frame_first_i,
  input logic             skip_frame_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [PIX_W-1:0] pixel_out_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // Hold a stalled result and its value
  `IGO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `IGO_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(pixel_out_o))
  // Plain and skipped pixels give a result in the next cycle
  `IGO_ASSERT_NEXT(a_fast_path, clk_i, rst_ni, in_xfer && (!frame_first_i || skip_frame_i), out_valid_o)
  // A skipped frame starts with its pixel unchanged
  `IGO_ASSERT_NEXT(a_skip_pass, clk_i, rst_ni, in_xfer && frame_first_i && skip_frame_i, pixel_out_o == $past(pixel_in_i))

endmodule

bind interleave_grid_overlay igo_checker u_igo_checker (.*);
